### hdl/ksu_pkg.sv
`timescale 1ns / 1ps

package ksu_pkg;

  // Item kinds carried in tuser on the input channel.
  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_NONCE = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;
  localparam logic [1:0] REQ_DATA  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] CFG_KEY_LENGTH = 3'd4;

  localparam logic [5:0] KEY_LENGTH_RESET = 6'd32;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_FETCH,
    OP_BEGIN_INIT,
    OP_LOAD,
    OP_ROUND_INIT,
    OP_ROUND_RD,
    OP_ROUND_WR,
    OP_ROUND_DONE,
    OP_NONCE_RD,
    OP_NONCE_WR,
    OP_DATA_RD,
    OP_DATA_WR,
    OP_EMIT
  } dp_op_t;

  // Branch conditions of the sequencer.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_NOT_IDX_LAST,
    C_NOT_ROUND_LAST,
    C_NONCE_FULL,
    C_OUT_FREE
  } cond_t;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    U_FETCH,
    U_B_INIT,
    U_B_LOAD,
    U_R_INIT,
    U_R_READ,
    U_R_WRITE,
    U_R_DONE,
    U_N_READ,
    U_N_WRITE,
    U_D_READ,
    U_D_WRITE,
    U_EMIT
  } ustep_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    ustep_t tgt_true;
    ustep_t tgt_false;
  } uword_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } ctrl_t;

  typedef struct packed {
    logic idx_last;
    logic round_last;
    logic nonce_full;
    logic out_free;
  } flags_t;

  // The control store. Each word names its operation, the branch condition,
  // and where to go when the condition holds or fails.
  function automatic uword_t ucode(ustep_t s);
    uword_t w;
    unique case (s)
      U_FETCH:   w = '{OP_FETCH,      C_DISPATCH,       U_FETCH,  U_FETCH};
      U_B_INIT:  w = '{OP_BEGIN_INIT, C_NEVER,          U_B_LOAD, U_B_LOAD};
      U_B_LOAD:  w = '{OP_LOAD,       C_NOT_IDX_LAST,   U_B_LOAD, U_R_INIT};
      U_R_INIT:  w = '{OP_ROUND_INIT, C_NEVER,          U_R_READ, U_R_READ};
      U_R_READ:  w = '{OP_ROUND_RD,   C_NEVER,          U_R_WRITE, U_R_WRITE};
      U_R_WRITE: w = '{OP_ROUND_WR,   C_NOT_ROUND_LAST, U_R_READ, U_R_DONE};
      U_R_DONE:  w = '{OP_ROUND_DONE, C_ALWAYS,         U_EMIT,   U_EMIT};
      U_N_READ:  w = '{OP_NONCE_RD,   C_NONCE_FULL,     U_EMIT,   U_N_WRITE};
      U_N_WRITE: w = '{OP_NONCE_WR,   C_ALWAYS,         U_EMIT,   U_EMIT};
      U_D_READ:  w = '{OP_DATA_RD,    C_NEVER,          U_D_WRITE, U_D_WRITE};
      U_D_WRITE: w = '{OP_DATA_WR,    C_NEVER,          U_EMIT,   U_EMIT};
      U_EMIT:    w = '{OP_EMIT,       C_OUT_FREE,       U_FETCH,  U_EMIT};
      default:   w = '{OP_FETCH,      C_NEVER,          U_FETCH,  U_FETCH};
    endcase
    return w;
  endfunction

endpackage

### hdl/ksu_state_ram.sv
`timescale 1ns / 1ps

// Mixing state store: one write port, two registered read ports.
// Valid bits make entries that were never written read as zero.
module ksu_state_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [7:0]    rdata_a,
  output logic [7:0]    rdata_b
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [7:0]       rdata_a_r;
  logic [7:0]       rdata_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= valid_r[raddr_a] ? mem[raddr_a] : 8'h00;
    rdata_b_r <= valid_r[raddr_b] ? mem[raddr_b] : 8'h00;
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

### hdl/ksu_sequencer.sv
`timescale 1ns / 1ps

// Microprogram counter and branch unit over the control store.
module ksu_sequencer
  import ksu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] req_type,
  input  flags_t     flags,
  output logic       in_tready,
  output ctrl_t      ctrl
);

  ustep_t upc_r;
  ustep_t upc_nxt;
  uword_t uw;
  logic   cond_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    uw      = ucode(upc_r);
    cond_ok = 1'b0;
    upc_nxt = U_FETCH;
    unique case (uw.cond)
      C_NEVER:          cond_ok = 1'b0;
      C_ALWAYS:         cond_ok = 1'b1;
      C_DISPATCH:       cond_ok = 1'b0;
      C_NOT_IDX_LAST:   cond_ok = !flags.idx_last;
      C_NOT_ROUND_LAST: cond_ok = !flags.round_last;
      C_NONCE_FULL:     cond_ok = flags.nonce_full;
      C_OUT_FREE:       cond_ok = flags.out_free;
      default:          cond_ok = 1'b0;
    endcase
    if (uw.cond == C_DISPATCH) begin
      if (in_tvalid) begin
        unique case (req_type)
          REQ_BEGIN: upc_nxt = U_B_INIT;
          REQ_NONCE: upc_nxt = U_N_READ;
          REQ_END:   upc_nxt = U_R_INIT;
          REQ_DATA:  upc_nxt = U_D_READ;
          default:   upc_nxt = U_FETCH;
        endcase
      end else begin
        upc_nxt = uw.tgt_false;
      end
    end else begin
      upc_nxt = cond_ok ? uw.tgt_true : uw.tgt_false;
    end
    in_tready   = (upc_r == U_FETCH);
    ctrl.op     = uw.op;
    ctrl.accept = (upc_r == U_FETCH) && in_tvalid;
  end

`ifndef SYNTHESIS
  a_leave_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.accept |=> !in_tready)
    else $error("sequencer stayed at fetch after a transaction");
`endif

endmodule

### hdl/ksu_datapath.sv
`timescale 1ns / 1ps

// Registers, adders and the state store, driven by one operation per cycle.
module ksu_datapath
  import ksu_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 32,
  parameter int MIX_ROUNDS    = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  ctrl_t        ctrl,
  output flags_t       flags,
  input  logic [255:0] key_all,
  input  logic [5:0]   key_len,
  input  logic [7:0]   in_byte,
  input  logic         out_tready,
  output logic         out_tvalid,
  output logic [7:0]   out_byte,
  output logic         out_status
);

  localparam int IW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
  localparam int RW  = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
  localparam logic [6:0] MAXK7 = 7'(MAX_KEY_BYTES);

  logic [7:0]    acc_r, acc_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [7:0]    bc_r, bc_nxt;
  logic [LW-1:0] nc_r, nc_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [RW-1:0] rcnt_r, rcnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    byte_r;
  logic [7:0]    res_byte_r;
  logic          res_status_r;
  logic [7:0]    out_byte_r;
  logic          out_status_r;

  logic          we;
  logic [IW-1:0] waddr;
  logic [7:0]    wdata;
  logic [IW-1:0] ra;
  logic [IW-1:0] rb;
  logic [7:0]    rda;
  logic [7:0]    rdb;

  logic [6:0]    kl7;
  logic [6:0]    len7;
  logic [LW-1:0] len;
  logic [IW-1:0] p;
  logic [LW-1:0] p1;
  logic [IW-1:0] nx;
  logic [LW-1:0] i1;
  logic [IW-1:0] idx_wrap;
  logic [5:0]    i6;
  logic [7:0]    key_b;
  logic [7:0]    load_v;
  logic [7:0]    v_round;
  logic [7:0]    v_nonce;
  logic [7:0]    v_data;
  logic          out_free;

  ksu_state_ram #(
    .DEPTH (MAX_KEY_BYTES),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rda),
    .rdata_b (rdb)
  );

  always_comb begin
    // Effective key length: zero counts as one, clamp at the store depth.
    kl7  = {1'b0, key_len};
    if (kl7 == 7'd0) begin
      len7 = 7'd1;
    end else if (kl7 > MAXK7) begin
      len7 = MAXK7;
    end else begin
      len7 = kl7;
    end
    len = LW'(len7);

    // A stale position beyond the current length restarts at zero.
    p  = (LW'(pos_r) < len) ? pos_r : '0;
    p1 = LW'(p) + LW'(1);
    nx = (p1 >= len) ? '0 : IW'(p1);

    i1       = LW'(idx_r) + LW'(1);
    idx_wrap = (i1 >= len) ? '0 : IW'(i1);

    i6     = 6'(idx_r);
    key_b  = i6[5] ? 8'h00 : key_all[{i6[4:0], 3'b000} +: 8];
    load_v = (LW'(idx_r) < len) ? key_b : 8'h00;

    v_round = rda + acc_r;
    v_nonce = rda + byte_r;
    v_data  = rda + rdb + acc_r;

    out_free = !out_valid_r || out_tready;

    flags.idx_last   = (idx_r == IW'(MAX_KEY_BYTES - 1));
    flags.round_last = (rcnt_r == RW'(MIX_ROUNDS - 1));
    flags.nonce_full = (nc_r >= LW'(MAX_KEY_BYTES));
    flags.out_free   = out_free;
  end

  always_comb begin
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    bc_nxt   = bc_r;
    nc_nxt   = nc_r;
    idx_nxt  = idx_r;
    rcnt_nxt = rcnt_r;
    we       = 1'b0;
    waddr    = idx_r;
    wdata    = 8'h00;
    ra       = idx_r;
    rb       = nx;
    unique case (ctrl.op)
      OP_FETCH: begin
      end
      OP_BEGIN_INIT: begin
        acc_nxt = 8'h00;
        idx_nxt = '0;
        nc_nxt  = '0;
      end
      OP_LOAD: begin
        // Entries past the key length are cleared on the same sweep.
        we      = 1'b1;
        wdata   = load_v;
        acc_nxt = acc_r + load_v;
        idx_nxt = flags.idx_last ? '0 : idx_r + IW'(1);
      end
      OP_ROUND_INIT: begin
        idx_nxt  = '0;
        rcnt_nxt = '0;
      end
      OP_ROUND_RD: begin
        ra = idx_r;
      end
      OP_ROUND_WR: begin
        we       = 1'b1;
        wdata    = v_round;
        acc_nxt  = acc_r + v_round;
        idx_nxt  = idx_wrap;
        rcnt_nxt = rcnt_r + RW'(1);
      end
      OP_ROUND_DONE: begin
        pos_nxt = '0;
        bc_nxt  = 8'h00;
      end
      OP_NONCE_RD: begin
        ra = IW'(nc_r);
      end
      OP_NONCE_WR: begin
        we      = 1'b1;
        waddr   = IW'(nc_r);
        wdata   = v_nonce;
        acc_nxt = acc_r + v_nonce;
        nc_nxt  = nc_r + LW'(1);
      end
      OP_DATA_RD: begin
        ra = p;
        rb = nx;
      end
      OP_DATA_WR: begin
        we      = 1'b1;
        waddr   = p;
        wdata   = v_data;
        acc_nxt = acc_r + v_data + bc_r;
        bc_nxt  = bc_r + 8'd1;
        pos_nxt = nx;
      end
      OP_EMIT: begin
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.op == OP_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 8'h00;
      pos_r       <= '0;
      bc_r        <= 8'h00;
      nc_r        <= '0;
      idx_r       <= '0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      bc_r        <= bc_nxt;
      nc_r        <= nc_nxt;
      idx_r       <= idx_nxt;
      rcnt_r      <= rcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_FETCH && ctrl.accept) begin
      byte_r       <= in_byte;
      res_byte_r   <= 8'h00;
      res_status_r <= 1'b0;
    end
    if (ctrl.op == OP_NONCE_RD && flags.nonce_full) begin
      res_status_r <= 1'b1;
    end
    if (ctrl.op == OP_DATA_WR) begin
      res_byte_r <= byte_r ^ v_data;
    end
    if (ctrl.op == OP_EMIT && out_free) begin
      out_byte_r   <= res_byte_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_byte_r == 8'h00))
    else $error("ignored nonce result carries a nonzero byte");
  a_nonce_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nc_r <= LW'(MAX_KEY_BYTES))
    else $error("nonce count ran past the state size");
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(ctrl.op) == OP_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule

### hdl/byte_stream_cipher_keystream_unit.sv
`timescale 1ns / 1ps

// Byte stream cipher keystream unit. Each input transaction carries a kind in
// in_tuser (begin message, nonce byte, end of nonce, data byte) and a byte in
// in_tdata, and produces exactly one output transaction: the data byte XORed
// with the keystream, or zero for other kinds, with a status flag that is set
// when a nonce byte arrives after MAX_KEY_BYTES nonce bytes and is ignored.
// Items are processed one at a time by a small microprogram; the output
// register lets the next item be accepted while a result is still waiting.
// Each item passes through the fetch step and its own operation steps and
// ends in the emit step, which waits until the output register is free.
// The state store's read data is registered, so every mixing round and every
// byte update is a read step followed by a write step, and the begin item
// first sweeps all MAX_KEY_BYTES entries once to load the key. Key registers
// and the key length are written through the cfg_ port, which is always
// ready; write them only while no item is in progress.
module byte_stream_cipher_keystream_unit
  import ksu_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 32,
  parameter int MIX_ROUNDS    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_in
  input  logic [1:0]  in_tuser,    // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] byte_out
  output logic [0:0]  out_tuser,   // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_word_r [4];
  logic [5:0]  key_len_r;
  logic        cfg_write;
  ctrl_t       ctrl;
  flags_t      flags;
  logic        out_status;

  // Configuration writes complete in the cycle they are offered. An index
  // beyond the register list is accepted and dropped.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word_r[0] <= 64'd0;
      key_word_r[1] <= 64'd0;
      key_word_r[2] <= 64'd0;
      key_word_r[3] <= 64'd0;
      key_len_r     <= KEY_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_addr)
        CFG_KEY_WORD_0: key_word_r[0] <= cfg_data;
        CFG_KEY_WORD_1: key_word_r[1] <= cfg_data;
        CFG_KEY_WORD_2: key_word_r[2] <= cfg_data;
        CFG_KEY_WORD_3: key_word_r[3] <= cfg_data;
        CFG_KEY_LENGTH: key_len_r     <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer steps through the control store and hands one operation
  // per cycle to the datapath, which reports back the loop and stall flags.
  ksu_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .flags     (flags),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  ksu_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .MIX_ROUNDS    (MIX_ROUNDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .flags      (flags),
    .key_all    ({key_word_r[3], key_word_r[2], key_word_r[1], key_word_r[0]}),
    .key_len    (key_len_r),
    .in_byte    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (out_tdata),
    .out_status (out_status)
  );

  assign out_tuser = out_status;

endmodule

### sim/byte_stream_cipher_keystream_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for the byte stream cipher keystream unit.
module byte_stream_cipher_keystream_unit_tb
  import ksu_pkg::*;
();

  localparam int CLK_PERIOD_NS = 20;
  localparam int RESET_CYCLES  = 11;
  // Watchdog limit, set well above the slowest legal run (every item a begin,
  // every gap and stall at its longest).
  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int ITEM_BUDGET   = 1150;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 40;
  localparam int KEY_BYTES     = 32;
  localparam int STIR_ROUNDS   = 256;
  localparam int REPORT_LIMIT  = 10;

  // An index that no register decodes; writes to it must leave the key alone.
  localparam logic [2:0] CFG_NO_REG = 3'd7;

  // Idle patterns shared by the sender and the receiver.
  typedef enum int {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_mode_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       status;
  } cipher_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] byte_in
  logic [1:0]  in_tuser;    // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [7:0] byte_out
  logic [0:0]  out_tuser;   // [0] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_addr;
  logic [63:0] cfg_data;

  byte_stream_cipher_keystream_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the key registers and of the cipher state. It is advanced
  // at the same clock edge at which the block accepts each transaction.
  logic [63:0] key_word_sh [4];
  logic [5:0]  key_len_sh;
  logic [7:0]  mix_sh [KEY_BYTES];
  logic [7:0]  acc_sh;
  int unsigned pos_sh;
  logic [7:0]  count_sh;
  int unsigned nonce_sh;

  // Results still owed by the block, oldest first.
  cipher_result_t awaited_results [$];

  int         mismatch_count;
  int         items_sent;
  idle_mode_t tx_mode;
  idle_mode_t rx_mode;
  int unsigned rx_stall_left;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD_NS);
    $display("byte_stream_cipher_keystream_unit verification failed");
    $finish;
  end

  // Length of the next idle stretch. Most stretches are short, a few long.
  function automatic int unsigned pick_idle(idle_mode_t mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      IDLE_LIGHT: begin
        if (r < 25) return $urandom_range(1, 3);
        if (r < 28) return $urandom_range(15, 60);
        return 0;
      end
      IDLE_HEAVY: begin
        if (r < 50) return $urandom_range(1, 4);
        if (r < 55) return $urandom_range(30, 90);
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  // Key length as the block uses it: zero acts as one, and anything above
  // the state size is clamped to the state size.
  function automatic int unsigned wrap_len();
    int unsigned n;
    n = key_len_sh;
    if (n == 0) n = 1;
    if (n > KEY_BYTES) n = KEY_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] key_byte_sh(int unsigned idx);
    if (idx >= KEY_BYTES) return 8'h00;
    return key_word_sh[idx >> 3][(idx % 8) * 8 +: 8];
  endfunction

  function automatic logic [63:0] pick_key_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 64'h0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic stir_rounds(int unsigned len);
    int unsigned idx;
    idx = 0;
    for (int r = 0; r < STIR_ROUNDS; r++) begin
      mix_sh[idx] = mix_sh[idx] + acc_sh;
      acc_sh      = acc_sh + mix_sh[idx];
      idx++;
      if (idx >= len) idx = 0;
    end
  endtask

  // Advances the shadow state by one transaction and returns the result
  // that the block must produce for it.
  task automatic keystream_step(input logic [1:0] kind, input logic [7:0] b,
                                output cipher_result_t res);
    int unsigned len;
    int unsigned p;
    int unsigned nx;
    len = wrap_len();
    res = '0;
    case (kind)
      REQ_BEGIN: begin
        foreach (mix_sh[i]) mix_sh[i] = 8'h00;
        acc_sh = 8'h00;
        for (int unsigned i = 0; i < len; i++) begin
          mix_sh[i] = key_byte_sh(i);
          acc_sh    = acc_sh + mix_sh[i];
        end
        stir_rounds(len);
        pos_sh   = 0;
        count_sh = 8'h00;
        nonce_sh = 0;
      end
      REQ_NONCE: begin
        // Once the state is full of nonce bytes, more of them are dropped
        // and flagged. Only a begin item clears the nonce count.
        if (nonce_sh < KEY_BYTES) begin
          mix_sh[nonce_sh] = mix_sh[nonce_sh] + b;
          acc_sh           = acc_sh + mix_sh[nonce_sh];
          nonce_sh++;
        end else begin
          res.status = 1'b1;
        end
      end
      REQ_END: begin
        stir_rounds(len);
        pos_sh   = 0;
        count_sh = 8'h00;
      end
      default: begin
        // A position left over from a longer key length restarts at zero.
        p  = (pos_sh < len) ? pos_sh : 0;
        nx = p + 1;
        if (nx >= len) nx = 0;
        mix_sh[p]    = mix_sh[p] + mix_sh[nx] + acc_sh;
        acc_sh       = acc_sh + mix_sh[p] + count_sh;
        res.byte_out = b ^ mix_sh[p];
        count_sh     = count_sh + 8'd1;
        pos_sh       = nx;
      end
    endcase
  endtask

  // Sends one item. The valid line is left high on return so that a
  // back-to-back item does not lower and raise it within one time step.
  task automatic push_item(input logic [1:0] kind, input logic [7:0] b);
    int unsigned gap;
    cipher_result_t res;
    gap = pick_idle(tx_mode);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    keystream_step(kind, b, res);
    awaited_results.push_back(res);
    items_sent++;
    @(negedge clk);
  endtask

  // Register write; like push_item it leaves the valid line high.
  task automatic write_reg(input logic [2:0] addr, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      CFG_KEY_WORD_0: key_word_sh[0] = data;
      CFG_KEY_WORD_1: key_word_sh[1] = data;
      CFG_KEY_WORD_2: key_word_sh[2] = data;
      CFG_KEY_WORD_3: key_word_sh[3] = data;
      CFG_KEY_LENGTH: key_len_sh = data[5:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Stops the sender and waits until every owed result has come back, then
  // settles so that the block is surely back at its fetch step.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the whole key setup. Only the low six bits of the length word
  // count, so the upper bits sometimes carry junk.
  task automatic load_key_setup(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [5:0] len);
    logic [63:0] len_word;
    len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'h0;
    len_word[5:0] = len;
    write_reg(CFG_KEY_WORD_0, k0);
    write_reg(CFG_KEY_WORD_1, k1);
    write_reg(CFG_KEY_WORD_2, k2);
    write_reg(CFG_KEY_WORD_3, k3);
    write_reg(CFG_KEY_LENGTH, len_word);
    cfg_valid <= 1'b0;
  endtask

  // The receiver: ready drops for random stretches, changed only at the
  // falling edge so that the checker sees a stable value.
  always @(negedge clk) begin
    if (rx_stall_left != 0) begin
      out_tready <= 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      rx_stall_left = pick_idle(rx_mode);
    end
  end

  // Every output transaction is matched against the oldest owed result.
  always @(posedge clk) begin : check_results
    cipher_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected output transaction: byte_out=%02h status=%0d",
                   out_tdata, out_tuser[0]);
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata !== want.byte_out || out_tuser[0] !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: byte_out exp %02h got %02h, status exp %0d got %0d",
                     want.byte_out, out_tdata, want.status, out_tuser[0]);
        end
      end
    end
  end

  // Data, nonce and end items sent before any begin item start from the all-zero reset state.
  task automatic test_before_begin();
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'hff);
    push_item(REQ_NONCE, 8'h80);
    push_item(REQ_END, 8'h00);
    push_item(REQ_DATA, 8'h01);
  endtask

  // All-ones key at full length, extreme nonce and data bytes.
  task automatic test_full_key();
    wait_idle();
    load_key_setup('1, '1, '1, '1, 6'd32);
    push_item(REQ_BEGIN, 8'hff);
    push_item(REQ_NONCE, 8'hff);
    push_item(REQ_NONCE, 8'h00);
    push_item(REQ_END, 8'hff);
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'hff);
  endtask

  // A zero length acts as one byte, lengths above the state size clamp, and
  // a write to an undecoded index changes nothing.
  task automatic test_key_length_limits();
    wait_idle();
    load_key_setup(pick_key_word(), pick_key_word(), pick_key_word(),
                   pick_key_word(), 6'd0);
    push_item(REQ_BEGIN, 8'h00);
    push_item(REQ_DATA, 8'h5a);
    wait_idle();
    load_key_setup(pick_key_word(), pick_key_word(), pick_key_word(),
                   pick_key_word(), 6'd63);
    @(negedge clk);
    write_reg(CFG_NO_REG, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    push_item(REQ_BEGIN, 8'h00);
    push_item(REQ_DATA, 8'ha5);
  endtask

  // More nonce bytes than the state holds: the excess is flagged, and the
  // count survives an end-of-nonce item.
  task automatic test_nonce_overflow();
    wait_idle();
    load_key_setup(pick_key_word(), pick_key_word(), pick_key_word(),
                   pick_key_word(), 6'd1);
    push_item(REQ_BEGIN, 8'h00);
    repeat (KEY_BYTES + 1) push_item(REQ_NONCE, 8'($urandom_range(0, 255)));
    push_item(REQ_END, 8'h00);
    push_item(REQ_NONCE, 8'hc3);
    push_item(REQ_DATA, 8'h3c);
  endtask

  // The position is left at five, then the key length shrinks to three.
  task automatic test_stale_position();
    wait_idle();
    load_key_setup(pick_key_word(), pick_key_word(), pick_key_word(),
                   pick_key_word(), 6'd32);
    push_item(REQ_BEGIN, 8'h00);
    push_item(REQ_END, 8'h00);
    repeat (5) push_item(REQ_DATA, 8'($urandom_range(0, 255)));
    wait_idle();
    load_key_setup(key_word_sh[0], key_word_sh[1], key_word_sh[2],
                   key_word_sh[3], 6'd3);
    repeat (2) push_item(REQ_DATA, 8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed messages (begin, nonce, end, data) with random
  // content and lengths, mixed with some noise and with messages that skip
  // the begin or the end. The key setup and idle patterns change now and then.
  task automatic test_random_sessions();
    int unsigned session;
    int unsigned r;
    int unsigned n_nonce;
    logic [5:0]  len;
    session = 0;
    while (items_sent < ITEM_BUDGET) begin
      if (session % 4 == 0) begin
        wait_idle();
        tx_mode = idle_mode_t'($urandom_range(0, 2));
        rx_mode = idle_mode_t'($urandom_range(0, 2));
        r = $urandom_range(0, 9);
        case (r)
          0:       len = 6'd0;
          1:       len = 6'd1;
          2:       len = 6'd32;
          3:       len = 6'($urandom_range(33, 63));
          4:       len = 6'd2;
          default: len = 6'($urandom_range(1, 32));
        endcase
        load_key_setup(pick_key_word(), pick_key_word(), pick_key_word(),
                       pick_key_word(), len);
      end
      session++;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 6))
          push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if (r >= 15) push_item(REQ_BEGIN, 8'($urandom_range(0, 255)));
        r = $urandom_range(0, 9);
        if (r < 7)      n_nonce = $urandom_range(1, 31);
        else if (r < 9) n_nonce = $urandom_range(32, 36);
        else            n_nonce = 0;
        repeat (n_nonce) push_item(REQ_NONCE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0) push_item(REQ_END, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 40)) push_item(REQ_DATA, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    in_tuser       = REQ_BEGIN;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_addr       = CFG_KEY_WORD_0;
    cfg_data       = 64'h0;
    rx_stall_left  = 0;
    tx_mode        = IDLE_NONE;
    rx_mode        = IDLE_NONE;
    mismatch_count = 0;
    items_sent     = 0;

    // Shadow state matches the block's reset values.
    foreach (key_word_sh[i]) key_word_sh[i] = 64'h0;
    key_len_sh = KEY_LENGTH_RESET;
    foreach (mix_sh[i]) mix_sh[i] = 8'h00;
    acc_sh   = 8'h00;
    pos_sh   = 0;
    count_sh = 8'h00;
    nonce_sh = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_before_begin();
    rx_mode = IDLE_LIGHT;
    test_full_key();
    tx_mode = IDLE_LIGHT;
    test_key_length_limits();
    test_nonce_overflow();
    test_stale_position();
    test_random_sessions();

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("byte_stream_cipher_keystream_unit verification clean");
    end else begin
      $display("byte_stream_cipher_keystream_unit verification failed");
    end
    $finish;
  end

endmodule

### byte_stream_cipher_keystream_unit.f
hdl/ksu_pkg.sv
hdl/ksu_state_ram.sv
hdl/ksu_sequencer.sv
hdl/ksu_datapath.sv
hdl/byte_stream_cipher_keystream_unit.sv
sim/byte_stream_cipher_keystream_unit_tb.sv
